[hw/rtl/tbli_pkg.sv]
// ----------------------------------------------------------------------------
// tbli_pkg - shared definitions for the table bisection interpolator
// Field widths, table geometry, request opcodes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbli_pkg;

	localparam int GRID_POINTS = 256;
	localparam int NUM_IONS    = 32;

	localparam int DATA_W  = 40;
	localparam int IDX_W   = $clog2(GRID_POINTS);
	localparam int ION_W   = $clog2(NUM_IONS);
	localparam int RADDR_W = ION_W + IDX_W;
	localparam int PIU_W   = 9;
	localparam int OP_W    = 2;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int HALF_W  = DATA_W / 2;
	localparam int MUL_W   = DATA_W + HALF_W;
	localparam int PROD_W  = 2 * DATA_W;
	localparam int UNIT_W  = DATA_W + 1;
	localparam int CNT_W   = $clog2(DATA_W);

	localparam logic [PIU_W-1:0] PIU_RESET = PIU_W'(250);

	localparam logic [OP_W-1:0] OP_GRID_WR = 2'd0;
	localparam logic [OP_W-1:0] OP_RATE_WR = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

	localparam logic [APB_AW-1:0] REG_PIU = 3'd0;

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_GN   = 16'b0000_0000_0000_0010,
		S_CHK  = 16'b0000_0000_0000_0100,
		S_BRD  = 16'b0000_0000_0000_1000,
		S_BCMP = 16'b0000_0000_0001_0000,
		S_FLO  = 16'b0000_0000_0010_0000,
		S_FHI  = 16'b0000_0000_0100_0000,
		S_FCAP = 16'b0000_0000_1000_0000,
		S_DIF0 = 16'b0000_0001_0000_0000,
		S_DIF1 = 16'b0000_0010_0000_0000,
		S_MUL0 = 16'b0000_0100_0000_0000,
		S_MUL1 = 16'b0000_1000_0000_0000,
		S_MUL2 = 16'b0001_0000_0000_0000,
		S_BIG  = 16'b0010_0000_0000_0000,
		S_DIV  = 16'b0100_0000_0000_0000,
		S_FIN  = 16'b1000_0000_0000_0000
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/table_bisect_linear_interp.sv]
// ----------------------------------------------------------------------------
// table_bisect_linear_interp - rate table lookup with linear interpolation
// Bisection over a shared temperature grid, then interpolation between the
// bracketing rate entries; compares, differences, division and the final add share one 41-bit add/subtract unit.
// ----------------------------------------------------------------------------
// Usage
//  Requests enter when start is high and busy is low. Opcode 0 writes a grid
//  temperature, opcode 1 writes a rate entry at (ion, entry_index); both
//  give no result and leave busy low. Opcode 3 is dropped.
//  Opcode 2 queries a rate: busy rises and stays high until the result is
//  shown on rate/extrapolated with done high for exactly one cycle. The
//  receiver cannot stall; a result is lost if not taken in that cycle.
//  A query runs from acceptance to done in these steps: two grid reads
//  at the ends, one read and one compare per bisection step (up to eight
//  steps), reads of the grid and rate entries at both bracket ends, three
//  differences through the shared unit, two partial products and their sum,
//  and a 40-step restoring division, one quotient bit per cycle through the shared adder, which dominates.
//  A zero grid span skips the division.
//  points_in_use sits at APB address 0; it is to be written only while idle, which the block does not enforce.
//  Reset sets points_in_use to 250 and returns the sequencer to idle; the
//  grid and rate memories are not cleared and must be written before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module table_bisect_linear_interp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [tbli_pkg::OP_W-1:0]         opcode,
	input  wire logic [tbli_pkg::ION_W-1:0]        ion,
	input  wire logic [tbli_pkg::IDX_W-1:0]        entry_index,
	input  wire logic [tbli_pkg::DATA_W-1:0]       entry_value,
	input  wire logic [tbli_pkg::DATA_W-1:0]       temperature,
	output logic                                   done,
	output logic [tbli_pkg::DATA_W-1:0]            rate,
	output logic                                   extrapolated,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tbli_pkg::APB_AW-1:0]       paddr,
	input  wire logic [tbli_pkg::APB_DW-1:0]       pwdata,
	output logic [tbli_pkg::APB_DW-1:0]            prdata,
	output logic                                   pready
);

	import tbli_pkg::*;

	localparam logic [DATA_W-1:0] MAX_RATE = {DATA_W{1'b1}};

	state_t state_q, state_d;

	logic [PIU_W-1:0]   piu_q;
	logic [PIU_W-1:0]   piu_m1;
	logic [IDX_W-1:0]   nm1;

	logic [DATA_W-1:0]  grid_mem [GRID_POINTS];
	logic [DATA_W-1:0]  rate_mem [GRID_POINTS*NUM_IONS];
	logic [DATA_W-1:0]  grid_rd_q, rate_rd_q;
	logic [IDX_W-1:0]   g_addr;
	logic [RADDR_W-1:0] r_addr;

	logic [DATA_W-1:0]  t_q, tlo_q, thi_q, rlo_q, rhi_q;
	logic [DATA_W-1:0]  a_q, b_q, d_q;
	logic               na_q, nb_q, nd_q, neg_q;
	logic [ION_W-1:0]   ion_q;
	logic [IDX_W-1:0]   lo_q, hi_q, mid_q;
	logic [IDX_W:0]     mid_sum;
	logic [IDX_W-1:0]   mid;
	logic [IDX_W-1:0]   lo_n, hi_n, span_n;
	logic               below_q, ext_q, big_q;
	logic [1:0]         dsel_q;
	logic [DATA_W-1:0]  dx, dy;

	logic [MUL_W-1:0]   m_q;
	logic [PROD_W-1:0]  p_q;
	logic [DATA_W-1:0]  rem_q, nsh_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [UNIT_W-1:0]  ua, ub;
	logic               usub;
	logic [UNIT_W:0]    usum;
	logic               ge;

	logic               sign;
	logic               done_q;
	logic [DATA_W-1:0]  rate_q;
	logic               extr_q;

	logic               req_acc, cfg_wr;

	assign req_acc = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign done         = done_q;
	assign rate         = rate_q;
	assign extrapolated = extr_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= PIU_RESET;
		end else if (cfg_wr && pready && paddr[APB_AW-1] == REG_PIU[APB_AW-1]) begin
			piu_q <= pwdata[PIU_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[APB_AW-1] == REG_PIU[APB_AW-1]) begin
			prdata = APB_DW'(piu_q);
		end
	end

	// last point in use, clamped to the grid
	assign piu_m1 = piu_q - PIU_W'(1);
	always_comb begin
		if (piu_q < PIU_W'(2)) begin
			nm1 = IDX_W'(1);
		end else if (piu_q > PIU_W'(GRID_POINTS)) begin
			nm1 = IDX_W'(GRID_POINTS - 1);
		end else begin
			nm1 = piu_m1[IDX_W-1:0];
		end
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IDX_W:1];

	// memory addresses
	always_comb begin
		unique case (state_q)
			S_GN:    g_addr = nm1;
			S_BRD:   g_addr = mid;
			S_FLO:   g_addr = lo_q;
			S_FHI:   g_addr = hi_q;
			default: g_addr = '0;
		endcase
		r_addr = {ion_q, (state_q == S_FLO) ? lo_q : hi_q};
	end

	always_ff @(posedge clk) begin
		if (req_acc && opcode == OP_GRID_WR) begin
			grid_mem[entry_index] <= entry_value;
		end
		grid_rd_q <= grid_mem[g_addr];
	end

	always_ff @(posedge clk) begin
		if (req_acc && opcode == OP_RATE_WR) begin
			rate_mem[{ion, entry_index}] <= entry_value;
		end
		rate_rd_q <= rate_mem[r_addr];
	end

	// difference operands
	always_comb begin
		case (dsel_q)
			2'd0:    begin dx = rhi_q; dy = rlo_q; end
			2'd1:    begin dx = t_q;   dy = tlo_q; end
			default: begin dx = thi_q; dy = tlo_q; end
		endcase
	end

	assign sign = na_q ^ nb_q ^ nd_q;

	// shared add/subtract unit
	always_comb begin
		ua   = {1'b0, t_q};
		ub   = {1'b0, grid_rd_q};
		usub = 1'b1;
		unique case (state_q)
			S_DIF0:  begin ua = {1'b0, dx}; ub = {1'b0, dy}; end
			S_DIF1:  begin ua = {1'b0, dy}; ub = {1'b0, dx}; end
			S_BIG:   begin ua = {1'b0, p_q[PROD_W-1:DATA_W]}; ub = {1'b0, d_q}; end
			S_DIV:   begin ua = {rem_q, nsh_q[DATA_W-1]}; ub = {1'b0, d_q}; end
			S_FIN:   begin ua = {1'b0, rlo_q}; ub = {1'b0, nsh_q}; usub = sign; end
			default: ;
		endcase
	end

	assign usum = {1'b0, ua} + {1'b0, (usub ? ~ub : ub)} + (UNIT_W+1)'(usub);
	assign ge   = usum[UNIT_W];

	// next bisection bounds
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (ge) begin
			lo_n = mid_q;
		end else begin
			hi_n = mid_q;
		end
		span_n = hi_n - lo_n;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_acc && opcode == OP_QUERY) state_d = S_GN;
			S_GN:   state_d = S_CHK;
			S_CHK: begin
				if (below_q || ge || nm1 <= IDX_W'(1)) state_d = S_FLO;
				else                                    state_d = S_BRD;
			end
			S_BRD:  state_d = S_BCMP;
			S_BCMP: state_d = (span_n > IDX_W'(1)) ? S_BRD : S_FLO;
			S_FLO:  state_d = S_FHI;
			S_FHI:  state_d = S_FCAP;
			S_FCAP: state_d = S_DIF0;
			S_DIF0: state_d = S_DIF1;
			S_DIF1: state_d = (dsel_q == 2'd2) ? S_MUL0 : S_DIF0;
			S_MUL0: state_d = S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_BIG;
			S_BIG:  state_d = (d_q == '0 || ge) ? S_FIN : S_DIV;
			S_DIV:  state_d = (cnt_q == CNT_W'(DATA_W - 1)) ? S_FIN : S_DIV;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q    <= temperature;
				ion_q  <= ion;
				dsel_q <= 2'd0;
			end
			S_GN: below_q <= !ge;
			S_CHK: begin
				if (below_q) begin
					lo_q  <= '0;
					hi_q  <= IDX_W'(1);
					ext_q <= 1'b1;
				end else if (ge) begin
					lo_q  <= nm1 - IDX_W'(1);
					hi_q  <= nm1;
					ext_q <= (t_q != grid_rd_q);
				end else begin
					lo_q  <= '0;
					hi_q  <= nm1;
					ext_q <= 1'b0;
				end
			end
			S_BRD: mid_q <= mid;
			S_BCMP: begin
				lo_q <= lo_n;
				hi_q <= hi_n;
			end
			S_FHI: begin
				tlo_q <= grid_rd_q;
				rlo_q <= rate_rd_q;
			end
			S_FCAP: begin
				thi_q <= grid_rd_q;
				rhi_q <= rate_rd_q;
			end
			S_DIF0: begin
				neg_q <= !ge;
				case (dsel_q)
					2'd0:    begin a_q <= usum[DATA_W-1:0]; na_q <= !ge; end
					2'd1:    begin b_q <= usum[DATA_W-1:0]; nb_q <= !ge; end
					default: begin d_q <= usum[DATA_W-1:0]; nd_q <= !ge; end
				endcase
			end
			S_DIF1: begin
				if (neg_q) begin
					case (dsel_q)
						2'd0:    a_q <= usum[DATA_W-1:0];
						2'd1:    b_q <= usum[DATA_W-1:0];
						default: d_q <= usum[DATA_W-1:0];
					endcase
				end
				dsel_q <= dsel_q + 2'd1;
			end
			S_MUL0: m_q <= MUL_W'(a_q) * MUL_W'(b_q[HALF_W-1:0]);
			S_MUL1: begin
				p_q <= {{(PROD_W-MUL_W){1'b0}}, m_q};
				m_q <= MUL_W'(a_q) * MUL_W'(b_q[DATA_W-1:HALF_W]);
			end
			S_MUL2: p_q <= p_q + {m_q, {HALF_W{1'b0}}};
			S_BIG: begin
				// quotient of 2^40 or more saturates either way
				big_q <= (d_q != '0) && ge;
				rem_q <= p_q[PROD_W-1:DATA_W];
				nsh_q <= (d_q == '0) ? '0 : p_q[DATA_W-1:0];
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= ge ? usum[DATA_W-1:0] : ua[DATA_W-1:0];
				nsh_q <= {nsh_q[DATA_W-2:0], ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_FIN: begin
				extr_q <= ext_q;
				if (big_q) begin
					rate_q <= sign ? '0 : MAX_RATE;
				end else if (nsh_q == '0) begin
					rate_q <= rlo_q;
				end else if (sign) begin
					rate_q <= ge ? usum[DATA_W-1:0] : '0;
				end else begin
					rate_q <= usum[DATA_W] ? MAX_RATE : usum[DATA_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// checks
	a_done_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result strobe without final step");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_QUERY) |=> busy)
		else $error("query request did not raise busy");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < d_q))
		else $error("division remainder not below divisor");

	a_bisect_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BRD) |-> (hi_q > lo_q + IDX_W'(1)))
		else $error("bisection bounds collapsed");

endmodule

`default_nettype wire
